/* rtl/core/gsr_pkg.sv */
// Shared types, register indexes, constants and the calibration curve for the
// gas sensor resistance to ppm converter. No dependencies.
package gsr_pkg;

	localparam int DIFF_LIMIT     = 400;
	localparam int CONC_CLAMP     = 100;
	localparam int DAC_DIV        = 100;
	localparam int CURVE_DATA_LEN = 102;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_FORMULA_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_RES_SUM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RES        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DAC_LOW        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DAC_HIGH       = 3'd5;

	localparam logic [1:0] MODE_F2 = 2'd2;

	localparam int MUL_A_W   = 31;
	localparam int MUL_B_W   = 18;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	localparam int DIV_N_W   = PROD_W;
	localparam int DIV_D_W   = 32;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam int DIST_W = 33;

	typedef struct packed {
		logic [12:0] reference_sum;
		logic [12:0] sensor_sum;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] resistance;
		logic [6:0]         concentration;
		logic [9:0]         dac_code;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_RLB,
		S_MUL_NUM,
		S_MUL_SD,
		S_DIV_RES,
		S_WALK_GO,
		S_WALK,
		S_MUL_DAC,
		S_DIV_DAC,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		W_IDLE,
		W_FIRST,
		W_STEP
	} walk_state_t;

	localparam logic [15:0] CURVE_DATA [CURVE_DATA_LEN] = '{
		16'd50400, 16'd47250, 16'd37800, 16'd31500, 16'd26250, 16'd23100, 16'd21000,
		16'd18900, 16'd17850, 16'd16800, 16'd15750, 16'd14785, 16'd13897, 16'd13083,
		16'd12341, 16'd11665, 16'd11053, 16'd10500, 16'd10002, 16'd9551, 16'd9135,
		16'd8746, 16'd8382, 16'd8043, 16'd7727, 16'd7435, 16'd7165, 16'd6917,
		16'd6691, 16'd6485, 16'd6300, 16'd6134, 16'd5986, 16'd5853, 16'd5733,
		16'd5623, 16'd5521, 16'd5424, 16'd5331, 16'd5239, 16'd5145, 16'd5048,
		16'd4949, 16'd4848, 16'd4746, 16'd4646, 16'd4548, 16'd4453, 16'd4363,
		16'd4278, 16'd4200, 16'd4130, 16'd4066, 16'd4009, 16'd3956, 16'd3906,
		16'd3860, 16'd3814, 16'd3769, 16'd3723, 16'd3675, 16'd3624, 16'd3571,
		16'd3517, 16'd3461, 16'd3405, 16'd3350, 16'd3297, 16'd3245, 16'd3196,
		16'd3150, 16'd3108, 16'd3070, 16'd3035, 16'd3003, 16'd2973, 16'd2944,
		16'd2917, 16'd2890, 16'd2863, 16'd2835, 16'd2806, 16'd2777, 16'd2747,
		16'd2716, 16'd2684, 16'd2652, 16'd2619, 16'd2586, 16'd2553, 16'd2520,
		16'd2487, 16'd2454, 16'd2421, 16'd2388, 16'd2356, 16'd2324, 16'd2293,
		16'd2263, 16'd2234, 16'd2205, 16'd2178
	};

	// entries past the stored data repeat the last point
	function automatic logic [15:0] curve_at(logic [7:0] idx);
		logic [15:0] val;
		if (idx >= 8'(CURVE_DATA_LEN)) begin
			val = CURVE_DATA[CURVE_DATA_LEN-1];
		end else begin
			val = CURVE_DATA[idx[6:0]];
		end
		return val;
	endfunction

	function automatic logic [DIST_W-1:0] curve_dist(logic signed [31:0] r, logic [15:0] t);
		logic signed [DIST_W:0] diff;
		diff = (DIST_W+1)'(r) - $signed((DIST_W+1)'(t));
		return diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
	endfunction

endpackage

/* rtl/core/gsr_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on gsr_pkg for operand and product widths.
module gsr_mul import gsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] mcand,
	input  logic [MUL_B_W-1:0] mplier,
	output logic               done,
	output logic [PROD_W-1:0]  prod
);

	logic [MUL_A_W-1:0]   mcand_q;
	logic [MUL_B_W-1:0]   mplier_q;
	logic [PROD_W-1:0]    acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [PROD_W-1:0]    partial;

	assign partial = mplier_q[MUL_B_W-1] ? PROD_W'(mcand_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= MUL_CNT_W'(MUL_B_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == MUL_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (cnt_q != '0) begin
			acc_q    <= {acc_q[PROD_W-2:0], 1'b0} + partial;
			mplier_q <= {mplier_q[MUL_B_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* rtl/core/gsr_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gsr_pkg for dividend and divisor widths.
module gsr_div import gsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               done,
	output logic [DIV_N_W-1:0] quot
);

	logic [DIV_N_W-1:0]   n_q;
	logic [DIV_D_W-1:0]   dv_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_D_W:0]     rem_sh;
	logic [DIV_D_W:0]     rem_sub;
	logic                 qbit;

	assign rem_sh  = {rem_q, n_q[DIV_N_W-1]};
	assign rem_sub = rem_sh - {1'b0, dv_q};
	assign qbit    = (rem_sh >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			dv_q  <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			n_q   <= {n_q[DIV_N_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

/* rtl/core/gsr_curve.sv */
// Nearest-point walk over the calibration curve, one entry per cycle.
// Depends on gsr_pkg for the curve function and the walk state type.
module gsr_curve import gsr_pkg::*; #(
	parameter int CURVE_POINTS = 102
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [31:0]              r,
	output logic                            done,
	output logic [$clog2(CURVE_POINTS)-1:0] idx
);

	localparam int IW = $clog2(CURVE_POINTS);
	localparam logic [IW-1:0] LAST = IW'(CURVE_POINTS - 1);

	walk_state_t       state_q, state_d;
	logic signed [31:0] r_q;
	logic [DIST_W-1:0] dist_q;
	logic [IW-1:0]     idx_q;
	logic              done_q, done_d;
	logic [15:0]       t_first;
	logic signed [DIST_W:0] diff_first;
	logic              above;
	logic [IW-1:0]     idx_nxt;
	logic [DIST_W-1:0] d_first;
	logic [DIST_W-1:0] d_next;
	logic              closer;

	assign t_first    = curve_at(8'd0);
	assign diff_first = (DIST_W+1)'(r_q) - $signed((DIST_W+1)'(t_first));
	assign above      = !diff_first[DIST_W] && (diff_first != '0);
	assign d_first    = curve_dist(r_q, t_first);
	assign idx_nxt    = idx_q + 1'b1;
	assign d_next     = curve_dist(r_q, curve_at(8'(idx_nxt)));
	assign closer     = (dist_q < d_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			W_IDLE: begin
				if (start) state_d = W_FIRST;
			end
			W_FIRST: begin
				if (above) begin
					done_d  = 1'b1;
					state_d = W_IDLE;
				end else begin
					state_d = W_STEP;
				end
			end
			W_STEP: begin
				if (closer || idx_nxt == LAST) begin
					done_d  = 1'b1;
					state_d = W_IDLE;
				end
			end
			default: state_d = W_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && start) begin
			r_q <= r;
		end
		if (state_q == W_FIRST) begin
			idx_q  <= '0;
			dist_q <= d_first;
		end else if (state_q == W_STEP && !closer) begin
			idx_q  <= idx_nxt;
			dist_q <= d_next;
		end
	end

	assign done = done_q;
	assign idx  = idx_q;

endmodule

/* rtl/core/gas_sensor_resistance_to_ppm.sv */
// Top level of the gas sensor resistance to ppm converter: config registers,
// sequencer and result register. Depends on gsr_pkg, gsr_mul, gsr_div, gsr_curve.
//
//   channel  signals                             width  direction
//   sample   sample_valid/sample_ready/sample    26     in
//   result   result_valid/result_ready/result    49     out
//   config   cfg_we/cfg_index/cfg_data           3+20   in
//
// One word at a time; the latency is set by the serial multiplier, the serial
// divider and the number of curve entries walked (up to CURVE_POINTS).
// Reset clears the sequencer and loads the register defaults.
// A stalled result holds in the output register; a new sample is taken meanwhile.
module gas_sensor_resistance_to_ppm import gsr_pkg::*; #(
	parameter int CURVE_POINTS = 102
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(CURVE_POINTS);

	state_t state_q, state_d;

	logic [1:0]  formula_mode_q;
	logic [17:0] load_res_q;
	logic [17:0] input_res_sum_q;
	logic [19:0] max_res_q;
	logic [9:0]  dac_low_q;
	logic [9:0]  dac_high_q;

	logic               mul_go;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               mul_done;
	logic [PROD_W-1:0]  mul_prod;

	logic               div_go;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic               div_neg;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quot;

	logic          walk_go;
	logic          walk_done;
	logic [IW-1:0] walk_idx;

	logic               sample_fire;
	logic               load_out;
	logic signed [13:0] d_in;
	logic [13:0]        dmag_in;
	logic               small_in;
	logic [12:0]        dmag_q;
	logic               dneg_q;
	logic [30:0]        rlb_q;
	logic [PROD_W-1:0]  num_q;
	logic [31:0]        r_q;
	logic               neg_q;
	logic [IW-1:0]      conc_q;
	logic [9:0]         code_q;
	logic               mode2;
	logic signed [32:0] sd;
	logic signed [32:0] den;
	logic [31:0]        den_mag;
	logic [31:0]        r_sat;
	logic signed [10:0] span;
	logic [9:0]         span_mag;
	logic [6:0]         clamp_c;
	logic [9:0]         q10;
	logic [9:0]         code;
	logic               result_valid_q;
	result_t            result_q;

	assign sample_fire = sample_valid && sample_ready;
	assign d_in        = $signed({1'b0, sample.reference_sum}) - $signed({1'b0, sample.sensor_sum});
	assign dmag_in     = d_in[13] ? 14'(-d_in) : d_in;
	assign small_in    = (dmag_in <= 14'(DIFF_LIMIT));
	assign mode2       = (formula_mode_q == MODE_F2);

	assign sd      = dneg_q ? -$signed({1'b0, mul_prod[31:0]}) : $signed({1'b0, mul_prod[31:0]});
	assign den     = sd - $signed({2'b0, rlb_q});
	assign den_mag = den[32] ? 32'(-den) : den[31:0];

	assign q10  = div_quot[9:0];
	assign code = dac_low_q + (neg_q ? (~q10 + 10'd1) : q10);

	assign span     = $signed({1'b0, dac_high_q}) - $signed({1'b0, dac_low_q});
	assign span_mag = span[10] ? 10'(-span) : span[9:0];
	assign clamp_c  = (32'(walk_idx) > CONC_CLAMP) ? 7'(CONC_CLAMP) : 7'(walk_idx);

	always_comb begin
		if (!neg_q) begin
			r_sat = (div_quot[DIV_N_W-1:31] != '0) ? 32'h7FFF_FFFF : div_quot[31:0];
		end else if (div_quot > DIV_N_W'(33'h1_0000_0000 >> 1)) begin
			r_sat = 32'h8000_0000;
		end else begin
			r_sat = 32'(-div_quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			formula_mode_q  <= 2'd1;
			load_res_q      <= 18'd10000;
			input_res_sum_q <= 18'd10000;
			max_res_q       <= 20'd90000;
			dac_low_q       <= 10'd465;
			dac_high_q      <= 10'd993;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMULA_MODE:  formula_mode_q  <= cfg_data[1:0];
				REG_LOAD_RES:      load_res_q      <= cfg_data[17:0];
				REG_INPUT_RES_SUM: input_res_sum_q <= cfg_data[17:0];
				REG_MAX_RES:       max_res_q       <= cfg_data;
				REG_DAC_LOW:       dac_low_q       <= cfg_data[9:0];
				REG_DAC_HIGH:      dac_high_q      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		load_out     = 1'b0;
		mul_go       = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_go       = 1'b0;
		div_n        = '0;
		div_d        = '0;
		div_neg      = 1'b0;
		walk_go      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					if (small_in) begin
						state_d = S_WALK_GO;
					end else begin
						mul_go  = 1'b1;
						mul_a   = MUL_A_W'(load_res_q);
						mul_b   = MUL_B_W'(sample.sensor_sum);
						state_d = S_MUL_RLB;
					end
				end
			end
			S_MUL_RLB: begin
				if (mul_done) begin
					if (mode2) begin
						mul_go  = 1'b1;
						mul_a   = mul_prod[MUL_A_W-1:0];
						mul_b   = input_res_sum_q;
						state_d = S_MUL_NUM;
					end else begin
						div_go  = 1'b1;
						div_n   = mul_prod;
						div_d   = DIV_D_W'(dmag_q);
						div_neg = dneg_q;
						state_d = S_DIV_RES;
					end
				end
			end
			S_MUL_NUM: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_A_W'(dmag_q);
					mul_b   = input_res_sum_q;
					state_d = S_MUL_SD;
				end
			end
			S_MUL_SD: begin
				if (mul_done) begin
					if (den == '0) begin
						state_d = S_WALK_GO;
					end else begin
						div_go  = 1'b1;
						div_n   = num_q;
						div_d   = den_mag;
						div_neg = den[32];
						state_d = S_DIV_RES;
					end
				end
			end
			S_DIV_RES: begin
				if (div_done) state_d = S_WALK_GO;
			end
			S_WALK_GO: begin
				walk_go = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				if (walk_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_A_W'(span_mag);
					mul_b   = MUL_B_W'(clamp_c);
					state_d = S_MUL_DAC;
				end
			end
			S_MUL_DAC: begin
				if (mul_done) begin
					div_go  = 1'b1;
					div_n   = mul_prod;
					div_d   = DIV_D_W'(DAC_DIV);
					div_neg = span[10];
					state_d = S_DIV_DAC;
				end
			end
			S_DIV_DAC: begin
				if (div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			dmag_q <= dmag_in[12:0];
			dneg_q <= d_in[13];
			r_q    <= 32'(max_res_q);
		end
		if (state_q == S_MUL_RLB && mul_done) rlb_q <= mul_prod[30:0];
		if (state_q == S_MUL_NUM && mul_done) num_q <= mul_prod;
		if (div_go) neg_q <= div_neg;
		if (state_q == S_DIV_RES && div_done) r_q <= r_sat;
		if (state_q == S_WALK && walk_done) conc_q <= walk_idx;
		if (state_q == S_DIV_DAC && div_done) code_q <= code;
		if (load_out) begin
			result_q.resistance    <= r_q;
			result_q.concentration <= 7'(conc_q);
			result_q.dac_code      <= code_q;
		end
	end

	gsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.mcand  (mul_a),
		.mplier (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	gsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_quot)
	);

	gsr_curve #(
		.CURVE_POINTS (CURVE_POINTS)
	) u_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_go),
		.r      ($signed(r_q)),
		.done   (walk_done),
		.idx    (walk_idx)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/core/gsr_chk.sv */
// Port-level checker for gas_sensor_resistance_to_ppm, bound to the top level.
// Depends on gsr_pkg for the result word type.
module gsr_chk import gsr_pkg::*; #(
	parameter int CURVE_POINTS = 102
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_valid,
	input logic                  sample_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input result_t               result,
	input logic                  cfg_we
);

	logic [1:0] pending_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = sample_valid && sample_ready;
	assign out_fire = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_fire) - 2'(out_fire);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word dropped or changed while stalled");

	a_no_extra_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> pending_q != 2'd0)
		else $error("result word without a matching sample word");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !sample_ready)
		else $error("sample taken while another is in work");

	a_conc_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(result.concentration) <= CURVE_POINTS - 1)
		else $error("concentration beyond the curve");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> pending_q == 2'd0)
		else $error("config written while a word is in flight");

endmodule

bind gas_sensor_resistance_to_ppm gsr_chk #(
	.CURVE_POINTS (CURVE_POINTS)
) u_gsr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_we       (cfg_we)
);
